>>> rtl/core/fpha_pkg.sv
// Shared types and codes of the fit-policy heap allocator.
`timescale 1ns / 1ps

package fpha_pkg;

   // Result status codes.
   typedef enum logic [2:0] {
      ST_OK          = 3'd0,
      ST_ZERO_SIZE   = 3'd1,
      ST_NO_MEMORY   = 3'd2,
      ST_TABLE_FULL  = 3'd3,
      ST_UNKNOWN     = 3'd4,
      ST_DOUBLE_FREE = 3'd5
   } status_type;

   // Search policies.
   typedef enum logic [1:0] {
      FIT_FIRST = 2'd0,
      FIT_NEXT  = 2'd1,
      FIT_BEST  = 2'd2,
      FIT_WORST = 2'd3
   } fit_type;

   // Operation kinds.
   typedef enum logic {
      KIND_ALLOC   = 1'b0,
      KIND_RELEASE = 1'b1
   } kind_type;

   // Configuration register indexes.
   typedef enum logic {
      REG_FIT_POLICY = 1'b0,
      REG_HEAP_LIMIT = 1'b1
   } reg_type;

   // Per-field write enables of the block table.
   typedef struct packed {
      logic base;
      logic len;
      logic free;
      logic succ;
   } fld_we_type;

   // Sequencer states.
   typedef enum logic [3:0] {
      S_IDLE,
      S_WALK,
      S_PLACE,
      S_FIX,
      S_GROW,
      S_LINK,
      S_SCAN,
      S_REL_CHK,
      S_DONE
   } state_type;

endpackage

>>> rtl/core/fpha_ifs.sv
// Channel interfaces of the fit-policy heap allocator.
`timescale 1ns / 1ps

interface fpha_req_if;
   logic        valid;
   logic        ready;
   logic        kind;
   logic [31:0] request_size;
   logic [31:0] data_address;
   modport source(output valid, kind, request_size, data_address, input ready);
   modport sink(input valid, kind, request_size, data_address, output ready);
endinterface

interface fpha_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic [31:0] granted_address;
   logic [31:0] granted_size;
   modport source(output valid, status, granted_address, granted_size, input ready);
   modport sink(input valid, status, granted_address, granted_size, output ready);
endinterface

interface fpha_csr_if;
   logic        valid;
   logic        ready;
   logic        index;
   logic [31:0] data;
   modport source(output valid, index, data, input ready);
   modport sink(input valid, index, data, output ready);
endinterface

>>> rtl/core/fpha_blk_ram.sv
// Block table memory with per-field write enables and a registered read.
`timescale 1ns / 1ps

module fpha_blk_ram #(
   parameter int unsigned DEPTH     = 64,
   parameter int unsigned SUCC_BITS = 7
) (
   input  logic                              clock,
   input  fpha_pkg::fld_we_type              wr_en,
   input  logic [$clog2(DEPTH)-1:0]          wr_addr,
   input  logic [31:0]                       wr_base,
   input  logic [31:0]                       wr_len,
   input  logic                              wr_free,
   input  logic [SUCC_BITS-1:0]              wr_succ,
   input  logic [$clog2(DEPTH)-1:0]          rd_addr,
   output logic [31:0]                       rd_base,
   output logic [31:0]                       rd_len,
   output logic                              rd_free,
   output logic [SUCC_BITS-1:0]              rd_succ
);
   import fpha_pkg::*;

   logic [31:0]          base_mem [DEPTH];
   logic [31:0]          len_mem  [DEPTH];
   logic                 free_mem [DEPTH];
   logic [SUCC_BITS-1:0] succ_mem [DEPTH];

   // Write only the fields that are enabled.
   always_ff @(posedge clock) begin
      if (wr_en.base) base_mem[wr_addr] <= wr_base;
      if (wr_en.len)  len_mem[wr_addr]  <= wr_len;
      if (wr_en.free) free_mem[wr_addr] <= wr_free;
      if (wr_en.succ) succ_mem[wr_addr] <= wr_succ;
   end

   // Read data appears in the cycle after the address.
   always_ff @(posedge clock) begin
      rd_base <= base_mem[rd_addr];
      rd_len  <= len_mem[rd_addr];
      rd_free <= free_mem[rd_addr];
      rd_succ <= succ_mem[rd_addr];
   end

endmodule

>>> rtl/core/fit_policy_heap_allocator_top.sv
// Top level of the fit-policy heap allocator: sequencer around the block table.
`timescale 1ns / 1ps

// Usage:
// The req_ch channel carries allocate and release transactions; every one
// yields exactly one rsp_ch transaction with a status, a granted data address
// and a granted size. The csr_ch channel writes the fit policy (index 0) and
// the heap limit (index 1); it is always ready and is meant to be written
// while no transaction is in flight.
// One transaction is worked on at a time. An allocate walks the address-ordered
// list one entry per cycle through the block table memory; under next fit it
// makes a second pass from the head when the first pass finds no fit.
// A release scans the table slots in order, one per cycle, until it finds the
// address. Zero-size allocates and null releases skip the walk and the scan.
// The result sits in an output register, so a new transaction is accepted while
// a finished result still waits; a stalled receiver holds only the finish of
// the following transaction. Reset clears the slot map, list pointers, rover,
// heap top and result valid flag, and resets the fit policy and heap limit; the
// table memory needs no clearing pass.

module fit_policy_heap_allocator_top #(
   parameter int unsigned MAX_BLOCKS   = 64,
   parameter int unsigned HEADER_BYTES = 24,
   parameter int unsigned ADDR_BITS    = 32
) (
   input  logic       clock,
   input  logic       reset,
   fpha_req_if.sink   req_ch,
   fpha_rsp_if.source rsp_ch,
   fpha_csr_if.sink   csr_ch
);
   import fpha_pkg::*;

   localparam int unsigned SW = $clog2(MAX_BLOCKS);
   localparam int unsigned IW = $clog2(MAX_BLOCKS + 1);
   localparam logic [IW-1:0] NONE = IW'(MAX_BLOCKS);
   localparam logic [IW-1:0] LAST_STEP = IW'(MAX_BLOCKS - 1);
   localparam logic [32:0] HDR = 33'(HEADER_BYTES);
   localparam logic [31:0] ADDR_CAP =
      (ADDR_BITS >= 32) ? 32'hFFFF_FFFF : 32'((64'd1 << ADDR_BITS) - 64'd1);

   // Control and payload registers.
   state_type             state_ff, state_in;
   logic [32:0]           size_ff;
   logic [31:0]           addr_ff;
   fit_type               fit_ff;
   logic [31:0]           limit_ff;
   logic [MAX_BLOCKS-1:0] used_ff;
   logic [IW-1:0]         head_ff, tail_ff, rover_ff;
   logic [31:0]           top_ff;
   logic [IW-1:0]         cur_ff, cnt_ff, new_ff, scan_ff;
   logic                  pass_ff, sv_ff, chk_vld_ff;
   logic [SW-1:0]         chk_idx_ff;
   logic [IW-1:0]         pick_ff, pick_succ_ff;
   logic [31:0]           pick_base_ff, pick_len_ff;
   status_type            res_status_ff;
   logic [31:0]           res_addr_ff, res_size_ff;
   logic                  rsp_valid_ff;
   status_type            rsp_status_ff;
   logic [31:0]           rsp_addr_ff, rsp_size_ff;

   // Table memory port.
   fld_we_type    wr_en;
   logic [SW-1:0] wr_addr, rd_addr;
   logic [31:0]   wr_base, wr_len, rd_base, rd_len;
   logic          wr_free, rd_free;
   logic [IW-1:0] wr_succ, rd_succ;

   fpha_blk_ram #(
      .DEPTH     (MAX_BLOCKS),
      .SUCC_BITS (IW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_base (wr_base),
      .wr_len  (wr_len),
      .wr_free (wr_free),
      .wr_succ (wr_succ),
      .rd_addr (rd_addr),
      .rd_base (rd_base),
      .rd_len  (rd_len),
      .rd_free (rd_free),
      .rd_succ (rd_succ)
   );

   function automatic logic slot_ok(logic [IW-1:0] i, logic [MAX_BLOCKS-1:0] u);
      return (i < NONE) && u[i[SW-1:0]];
   endfunction

   function automatic logic [IW-1:0] first_free(logic [MAX_BLOCKS-1:0] u);
      logic [IW-1:0] r;
      r = NONE;
      for (int i = MAX_BLOCKS - 1; i >= 0; i--) begin
         if (!u[i]) r = IW'(i);
      end
      return r;
   endfunction

   // Shared combinational terms.
   logic [32:0]   aligned;
   logic [IW-1:0] start_idx, nxt, free_idx;
   logic          first_like, fits, better, take, walk_end, restart, found_first;
   logic          split_ok, grow_ok, grow_over, hit, miss_end, merge;
   logic [31:0]   eff_limit;

   always_comb begin
      aligned     = {1'b0, (req_ch.request_size - 32'd1) & 32'hFFFF_FFFC} + 33'd4;
      start_idx   = (fit_ff == FIT_NEXT && slot_ok(rover_ff, used_ff)) ? rover_ff : head_ff;
      first_like  = (fit_ff == FIT_FIRST) || (fit_ff == FIT_NEXT);
      fits        = rd_free && ({1'b0, rd_len} >= size_ff);
      better      = (pick_ff == NONE) ||
                    ((fit_ff == FIT_BEST) ? (rd_len < pick_len_ff) : (rd_len > pick_len_ff));
      take        = fits && (first_like || better);
      found_first = fits && first_like;
      nxt         = slot_ok(rd_succ, used_ff) ? rd_succ : NONE;
      walk_end    = (nxt == NONE) || (cnt_ff == LAST_STEP);
      restart     = walk_end && !found_first && (fit_ff == FIT_NEXT) && !pass_ff &&
                    slot_ok(head_ff, used_ff);
      free_idx    = first_free(used_ff);
      split_ok    = ({2'b0, pick_len_ff} > ({1'b0, size_ff} + {1'b0, HDR})) &&
                    (free_idx != NONE);
      eff_limit   = (limit_ff > ADDR_CAP) ? ADDR_CAP : limit_ff;
      grow_over   = ({2'b0, top_ff} + {1'b0, HDR} + {1'b0, size_ff}) > {2'b0, eff_limit};
      grow_ok     = (free_idx != NONE) && !grow_over;
      hit         = chk_vld_ff && used_ff[chk_idx_ff] &&
                    (({1'b0, rd_base} + HDR) == {1'b0, addr_ff});
      miss_end    = !chk_vld_ff && (scan_ff == NONE);
      merge       = sv_ff && rd_free &&
                    ({2'b0, rd_base} ==
                     ({2'b0, pick_base_ff} + {1'b0, HDR} + {2'b0, pick_len_ff}));
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_ch.valid) begin
               if (req_ch.kind == KIND_RELEASE) begin
                  state_in = (req_ch.data_address == 32'd0) ? S_DONE : S_SCAN;
               end else if (req_ch.request_size == 32'd0) begin
                  state_in = S_DONE;
               end else begin
                  state_in = slot_ok(start_idx, used_ff) ? S_WALK : S_GROW;
               end
            end
         end
         S_WALK: begin
            if (found_first) begin
               state_in = S_PLACE;
            end else if (!walk_end || restart) begin
               state_in = S_WALK;
            end else if (!first_like && (pick_ff != NONE || take)) begin
               state_in = S_PLACE;
            end else begin
               state_in = S_GROW;
            end
         end
         S_PLACE: state_in = split_ok ? S_FIX : S_DONE;
         S_FIX:   state_in = S_DONE;
         S_GROW: begin
            state_in = (grow_ok && slot_ok(head_ff, used_ff) && slot_ok(tail_ff, used_ff))
                       ? S_LINK : S_DONE;
         end
         S_LINK: state_in = S_DONE;
         S_SCAN: begin
            if (hit) state_in = rd_free ? S_DONE : S_REL_CHK;
            else if (miss_end) state_in = S_DONE;
         end
         S_REL_CHK: state_in = S_DONE;
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ch.ready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Memory port drive.
   always_comb begin
      rd_addr = '0;
      wr_en   = '0;
      wr_addr = pick_ff[SW-1:0];
      wr_base = pick_base_ff;
      wr_len  = pick_len_ff;
      wr_free = 1'b0;
      wr_succ = pick_succ_ff;
      unique case (state_ff)
         S_IDLE: rd_addr = start_idx[SW-1:0];
         S_WALK: begin
            if (!walk_end) rd_addr = nxt[SW-1:0];
            else if (restart) rd_addr = head_ff[SW-1:0];
         end
         S_PLACE: begin
            wr_en.len  = split_ok;
            wr_en.free = 1'b1;
            wr_en.succ = split_ok;
            wr_len     = size_ff[31:0];
            wr_succ    = free_idx;
         end
         S_FIX: begin
            wr_en   = '1;
            wr_addr = new_ff[SW-1:0];
            wr_base = pick_base_ff + HDR[31:0] + size_ff[31:0];
            wr_len  = pick_len_ff - HDR[31:0] - size_ff[31:0];
            wr_free = 1'b1;
            wr_succ = pick_succ_ff;
         end
         S_GROW: begin
            wr_en   = grow_ok ? '1 : '0;
            wr_addr = free_idx[SW-1:0];
            wr_base = top_ff;
            wr_len  = size_ff[31:0];
            wr_succ = NONE;
         end
         S_LINK: begin
            wr_en.succ = 1'b1;
            wr_succ    = new_ff;
         end
         S_SCAN: rd_addr = hit ? rd_succ[SW-1:0] : scan_ff[SW-1:0];
         S_REL_CHK: begin
            wr_en.free = 1'b1;
            wr_en.len  = merge;
            wr_en.succ = merge;
            wr_free    = 1'b1;
            wr_len     = pick_len_ff + rd_len + HDR[31:0];
            wr_succ    = rd_succ;
         end
         S_DONE: rd_addr = '0;
         default: rd_addr = '0;
      endcase
   end

   // Sequencer registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         fit_ff       <= FIT_FIRST;
         limit_ff     <= 32'd1048576;
         used_ff      <= '0;
         head_ff      <= NONE;
         tail_ff      <= NONE;
         rover_ff     <= NONE;
         top_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;

         // Configuration writes.
         if (csr_ch.valid) begin
            unique case (reg_type'(csr_ch.index))
               REG_FIT_POLICY: fit_ff   <= fit_type'(csr_ch.data[1:0]);
               REG_HEAP_LIMIT: limit_ff <= csr_ch.data;
            endcase
         end

         // The result register fills on completion and empties once taken.
         if (state_ff == S_DONE && (!rsp_valid_ff || rsp_ch.ready)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            S_IDLE: begin
               if (req_ch.valid) begin
                  size_ff       <= aligned;
                  addr_ff       <= req_ch.data_address;
                  cur_ff        <= start_idx;
                  cnt_ff        <= '0;
                  pass_ff       <= 1'b0;
                  pick_ff       <= NONE;
                  scan_ff       <= '0;
                  chk_vld_ff    <= 1'b0;
                  res_addr_ff   <= '0;
                  res_size_ff   <= '0;
                  res_status_ff <= (req_ch.kind == KIND_ALLOC && req_ch.request_size == 32'd0)
                                   ? ST_ZERO_SIZE : ST_OK;
               end
            end
            S_WALK: begin
               if (take) begin
                  pick_ff      <= cur_ff;
                  pick_base_ff <= rd_base;
                  pick_len_ff  <= rd_len;
                  pick_succ_ff <= rd_succ;
               end
               if (!found_first) begin
                  if (!walk_end) begin
                     cur_ff <= nxt;
                     cnt_ff <= cnt_ff + 1'b1;
                  end else if (restart) begin
                     cur_ff  <= head_ff;
                     cnt_ff  <= '0;
                     pass_ff <= 1'b1;
                  end
               end
            end
            S_PLACE: begin
               if (fit_ff == FIT_NEXT) rover_ff <= pick_ff;
               res_status_ff <= ST_OK;
               res_addr_ff   <= pick_base_ff + HDR[31:0];
               res_size_ff   <= split_ok ? size_ff[31:0] : pick_len_ff;
               if (split_ok) begin
                  used_ff[free_idx[SW-1:0]] <= 1'b1;
                  new_ff <= free_idx;
                  if (tail_ff == pick_ff) tail_ff <= free_idx;
               end
            end
            S_GROW: begin
               if (free_idx == NONE) begin
                  res_status_ff <= ST_TABLE_FULL;
               end else if (grow_over) begin
                  res_status_ff <= ST_NO_MEMORY;
               end else begin
                  used_ff[free_idx[SW-1:0]] <= 1'b1;
                  top_ff        <= top_ff + HDR[31:0] + size_ff[31:0];
                  res_status_ff <= ST_OK;
                  res_addr_ff   <= top_ff + HDR[31:0];
                  res_size_ff   <= size_ff[31:0];
                  new_ff        <= free_idx;
                  pick_ff       <= tail_ff;
                  tail_ff       <= free_idx;
                  if (!slot_ok(head_ff, used_ff)) begin
                     head_ff  <= free_idx;
                     rover_ff <= free_idx;
                  end
               end
            end
            S_SCAN: begin
               scan_ff    <= (scan_ff < NONE) ? scan_ff + 1'b1 : scan_ff;
               chk_vld_ff <= scan_ff < NONE;
               chk_idx_ff <= scan_ff[SW-1:0];
               if (hit) begin
                  pick_ff      <= IW'(chk_idx_ff);
                  pick_base_ff <= rd_base;
                  pick_len_ff  <= rd_len;
                  pick_succ_ff <= rd_succ;
                  sv_ff        <= slot_ok(rd_succ, used_ff);
                  if (rd_free) res_status_ff <= ST_DOUBLE_FREE;
               end else if (miss_end) begin
                  res_status_ff <= ST_UNKNOWN;
               end
            end
            S_REL_CHK: begin
               if (merge) begin
                  used_ff[pick_succ_ff[SW-1:0]] <= 1'b0;
                  if (tail_ff == pick_succ_ff) tail_ff <= pick_ff;
                  if (rover_ff == pick_succ_ff) rover_ff <= pick_ff;
               end
            end
            S_DONE: begin
               if (!rsp_valid_ff || rsp_ch.ready) begin
                  rsp_status_ff <= res_status_ff;
                  rsp_addr_ff   <= res_addr_ff;
                  rsp_size_ff   <= res_size_ff;
               end
            end
            default: ;
         endcase
      end
   end

   // Channel outputs.
   assign req_ch.ready           = (state_ff == S_IDLE);
   assign csr_ch.ready           = 1'b1;
   assign rsp_ch.valid           = rsp_valid_ff;
   assign rsp_ch.status          = rsp_status_ff;
   assign rsp_ch.granted_address = rsp_addr_ff;
   assign rsp_ch.granted_size    = rsp_size_ff;

endmodule

>>> tb/tb_fit_policy_heap_allocator_top.sv
// Self-checking testbench of the fit-policy heap allocator top level.
`timescale 1ns / 1ps

module tb_fit_policy_heap_allocator_top;
   import fpha_pkg::*;

   localparam int SLOTS = 64;
   localparam int HDR = 24;
   localparam int NONE = SLOTS;
   localparam int WATCHDOG_LIMIT = 6000;
   localparam int DRAIN_CYCLES = 2 * SLOTS + 20;
   localparam int PHASE_ITEMS = 200;

   // Heap predictor and store of expected responses.
   class heap_scoreboard;
      typedef struct {
         status_type  st;
         logic [31:0] addr;
         logic [31:0] size;
      } grant_t;

      fit_type          policy;
      logic [31:0]      limit;
      longint unsigned  base[SLOTS];
      longint unsigned  len[SLOTS];
      bit               is_free[SLOTS];
      int               succ[SLOTS];
      bit               used[SLOTS];
      int               head, tail, rov;
      longint unsigned  top;
      grant_t           pending[$];
      logic [31:0]      live[$];
      int               mismatches;

      function new();
         policy = FIT_FIRST;
         limit = 32'd1048576;
         foreach (used[i]) used[i] = 0;
         head = NONE;
         tail = NONE;
         rov = NONE;
         top = 0;
         mismatches = 0;
      endfunction

      function void write_reg(reg_type idx, logic [31:0] value);
         if (idx == REG_FIT_POLICY) policy = fit_type'(value[1:0]);
         else limit = value;
      endfunction

      function bit in_use(int i);
         return i < NONE && i >= 0 && used[i];
      endfunction

      function int follow(int i);
         return in_use(succ[i]) ? succ[i] : NONE;
      endfunction

      function int scan_first(int start, longint unsigned size);
         int cur, n;
         cur = in_use(start) ? start : NONE;
         n = 0;
         while (cur != NONE && n < SLOTS) begin
            if (is_free[cur] && len[cur] >= size) return cur;
            cur = follow(cur);
            n++;
         end
         return NONE;
      endfunction

      function int scan_extreme(longint unsigned size, bit want_small);
         int cur, pick, n;
         cur = in_use(head) ? head : NONE;
         pick = NONE;
         n = 0;
         while (cur != NONE && n < SLOTS) begin
            if (is_free[cur] && len[cur] >= size) begin
               if (pick == NONE || (want_small ? len[cur] < len[pick] : len[cur] > len[pick]))
                  pick = cur;
            end
            cur = follow(cur);
            n++;
         end
         return pick;
      endfunction

      function int find_fit(longint unsigned size);
         int found;
         case (policy)
            FIT_NEXT: begin
               found = scan_first(in_use(rov) ? rov : head, size);
               if (found == NONE) found = scan_first(head, size);
               if (found != NONE) rov = found;
            end
            FIT_BEST:  found = scan_extreme(size, 1'b1);
            FIT_WORST: found = scan_extreme(size, 1'b0);
            default:   found = scan_first(head, size);
         endcase
         return found;
      endfunction

      function int lowest_unused();
         for (int i = 0; i < SLOTS; i++) if (!used[i]) return i;
         return NONE;
      endfunction

      function grant_t make(status_type st, longint unsigned a, longint unsigned l);
         grant_t g;
         g.st = st;
         g.addr = a[31:0];
         g.size = l[31:0];
         return g;
      endfunction

      function grant_t allocate(logic [31:0] req);
         longint unsigned size, cap;
         int blk, ns;
         if (req == 0) return make(ST_ZERO_SIZE, 0, 0);
         size = (((longint'(req) - 1) >> 2) << 2) + 4;
         blk = find_fit(size);
         if (blk != NONE) begin
            // Split off the tail of the block when it leaves room for a header.
            if (len[blk] > size + HDR) begin
               ns = lowest_unused();
               if (ns != NONE) begin
                  used[ns] = 1;
                  base[ns] = base[blk] + HDR + size;
                  len[ns] = len[blk] - HDR - size;
                  is_free[ns] = 1;
                  succ[ns] = succ[blk];
                  succ[blk] = ns;
                  len[blk] = size;
                  if (tail == blk) tail = ns;
               end
            end
            is_free[blk] = 0;
            live.push_back(32'(base[blk] + HDR));
            return make(ST_OK, base[blk] + HDR, len[blk]);
         end
         // No fit: grow the heap at its top.
         ns = lowest_unused();
         if (ns == NONE) return make(ST_TABLE_FULL, 0, 0);
         cap = limit;
         if (top + HDR + size > cap) return make(ST_NO_MEMORY, 0, 0);
         used[ns] = 1;
         base[ns] = top;
         len[ns] = size;
         is_free[ns] = 0;
         succ[ns] = NONE;
         top += HDR + size;
         if (!in_use(head)) begin
            head = ns;
            rov = ns;
         end else if (in_use(tail)) begin
            succ[tail] = ns;
         end
         tail = ns;
         live.push_back(32'(base[ns] + HDR));
         return make(ST_OK, base[ns] + HDR, size);
      endfunction

      function grant_t give_back(logic [31:0] addr);
         int blk, s;
         blk = NONE;
         if (addr == 0) return make(ST_OK, 0, 0);
         for (int i = 0; i < SLOTS; i++) begin
            if (blk == NONE && used[i] && base[i] + HDR == addr) blk = i;
         end
         if (blk == NONE) return make(ST_UNKNOWN, 0, 0);
         if (is_free[blk]) return make(ST_DOUBLE_FREE, 0, 0);
         is_free[blk] = 1;
         // Merge with the following block when it is free and adjacent.
         s = follow(blk);
         if (s != NONE && is_free[s] && base[s] == base[blk] + HDR + len[blk]) begin
            len[blk] = (len[blk] + len[s] + HDR) & 64'hFFFF_FFFF;
            succ[blk] = succ[s];
            used[s] = 0;
            if (tail == s) tail = blk;
            if (rov == s) rov = blk;
         end
         return make(ST_OK, 0, 0);
      endfunction

      function void note(kind_type k, logic [31:0] req, logic [31:0] addr);
         if (k == KIND_ALLOC) pending.push_back(allocate(req));
         else pending.push_back(give_back(addr));
      endfunction

      function void check(logic [2:0] st, logic [31:0] addr, logic [31:0] size);
         grant_t g;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("Response with no request pending: status %0d", st);
            return;
         end
         g = pending.pop_front();
         if (st !== g.st || addr !== g.addr || size !== g.size) begin
            mismatches++;
            if (mismatches <= 10)
               $display("Mismatch: expected status %0d addr %h size %h, got %0d %h %h",
                        g.st, g.addr, g.size, st, addr, size);
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset;
   fpha_req_if req_ch();
   fpha_rsp_if rsp_ch();
   fpha_csr_if csr_ch();
   heap_scoreboard board = new();
   int idle_cycles = 0;
   int burst_left = 0;
   int rx_cycle = 0;

   fit_policy_heap_allocator_top dut (
      .clock(clock),
      .reset(reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch),
      .csr_ch(csr_ch)
   );

   always #10 clock = ~clock;

   // Receiver stalls in changing modes, including stretches of full readiness.
   always @(posedge clock) begin
      rx_cycle <= rx_cycle + 1;
      case ((rx_cycle / 700) % 4)
         0: rsp_ch.ready <= 1'b1;
         1: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
         2: rsp_ch.ready <= ((rx_cycle % 7) < 3);
         default: rsp_ch.ready <= $urandom_range(0, 1);
      endcase
   end

   // Monitor both channels and run the watchdog.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_ch.valid && req_ch.ready)
            board.note(kind_type'(req_ch.kind), req_ch.request_size, req_ch.data_address);
         if (rsp_ch.valid && rsp_ch.ready)
            board.check(rsp_ch.status, rsp_ch.granted_address, rsp_ch.granted_size);
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
             (csr_ch.valid && csr_ch.ready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   // Offer one transaction, pausing between bursts of random length.
   task automatic send(kind_type k, logic [31:0] req, logic [31:0] addr);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 6);
         if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      req_ch.valid <= 1'b1;
      req_ch.kind <= k;
      req_ch.request_size <= req;
      req_ch.data_address <= addr;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      burst_left--;
   endtask

   // Wait until every response is in and the block has settled.
   task automatic drain();
      req_ch.valid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (board.pending.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Write one register, then leave the channel idle.
   task automatic write_reg(reg_type idx, logic [31:0] value);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data <= value;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      board.write_reg(idx, value);
      csr_ch.valid <= 1'b0;
      @(posedge clock);
   endtask

   // One random transaction; alloc_pct sets the share of allocates.
   task automatic random_item(int alloc_pct);
      int r, pick;
      logic [31:0] a;
      r = $urandom_range(0, 99);
      if (r < alloc_pct) begin
         r = $urandom_range(0, 99);
         if (r < 3) send(KIND_ALLOC, 0, $urandom);
         else if (r < 6) send(KIND_ALLOC, $urandom, $urandom);
         else if (r < 8) send(KIND_ALLOC, $urandom_range(32'hFFFF_FFFD, 32'hFFFF_FFFF), 0);
         else if (r < 14) send(KIND_ALLOC, $urandom_range(1, 4000), 0);
         else send(KIND_ALLOC, $urandom_range(1, 160), 0);
      end else begin
         r = $urandom_range(0, 99);
         if (r < 4 || board.live.size() == 0) begin
            send(KIND_RELEASE, $urandom, (r % 2) ? 32'd0 : $urandom);
         end else if (r < 10) begin
            send(KIND_RELEASE, $urandom, $urandom);
         end else begin
            pick = $urandom_range(0, board.live.size() - 1);
            a = board.live[pick];
            // Mostly retire the address; keeping it now and then yields double frees.
            if (r >= 16) board.live.delete(pick);
            send(KIND_RELEASE, $urandom, a);
         end
      end
   endtask

   initial begin
      fit_type pol[8];
      logic [31:0] lim[8];
      reset <= 1'b1;
      req_ch.valid <= 1'b0;
      req_ch.kind <= KIND_ALLOC;
      req_ch.request_size <= 0;
      req_ch.data_address <= 0;
      csr_ch.valid <= 1'b0;
      csr_ch.index <= REG_FIT_POLICY;
      csr_ch.data <= 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part: size extremes, split, merge, null, unknown and double free.
      send(KIND_ALLOC, 32'd0, 0);
      send(KIND_ALLOC, 32'hFFFF_FFFF, 0);
      send(KIND_ALLOC, 32'hFFFF_FFFD, 0);
      send(KIND_ALLOC, 32'hFFFF_FFFC, 0);
      send(KIND_ALLOC, 32'd1, 0);
      send(KIND_ALLOC, 32'd100, 0);
      send(KIND_ALLOC, 32'd8, 0);
      send(KIND_RELEASE, 0, 32'd0);
      send(KIND_RELEASE, 0, 32'd5);
      send(KIND_RELEASE, 0, 32'hFFFF_FFFF);
      send(KIND_RELEASE, 0, 32'd52);
      send(KIND_RELEASE, 0, 32'd52);
      send(KIND_ALLOC, 32'd20, 0);
      send(KIND_RELEASE, 0, 32'd176);
      send(KIND_RELEASE, 0, 32'd52);
      send(KIND_RELEASE, 0, 32'd24);
      send(KIND_ALLOC, 32'd3, 0);
      board.live.delete();
      drain();

      // Fill the table to reach the table-full and unsplit-reuse cases.
      write_reg(REG_HEAP_LIMIT, 32'hFFFF_FFFF);
      for (int i = 0; i < 70; i++) send(KIND_ALLOC, $urandom_range(1, 64), 0);
      for (int i = 0; i < 20; i++) random_item(30);
      drain();

      pol = '{FIT_NEXT, FIT_BEST, FIT_WORST, FIT_FIRST, FIT_NEXT, FIT_BEST, FIT_WORST, FIT_FIRST};
      lim = '{32'd1048576, 32'hFFFF_FFFF, 32'd6000, 32'd0, $urandom, 32'd1048576,
              32'hFFFF_FFFF, $urandom_range(2000, 20000)};
      for (int p = 0; p < 8; p++) begin
         write_reg(REG_FIT_POLICY, {$urandom_range(0, 1) ? 30'h3FFF_FFFF : 30'd0, pol[p]});
         write_reg(REG_HEAP_LIMIT, lim[p]);
         for (int i = 0; i < PHASE_ITEMS; i++) random_item((p % 3 == 0) ? 65 : 52);
         drain();
      end

      if (board.mismatches == 0 && board.pending.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
